// ----- design/rfc_pkg.sv -----
// Rail fence cipher package: shared widths, register indexes, the request
// types that cross between front, queue and back, and the back-end state codes.
// No dependencies.
package rfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int RAIL_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = RAIL_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 1'd1;

    localparam logic [RAIL_W-1:0] RAIL_COUNT_RST = 7'd3;

    // one classified input request: keep is low when the buffer was full
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              keep;
    } item_t;

    // one result request waiting in the output queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              trunc;
    } out_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCATTER,
        ST_DRAIN,
        ST_EMIT
    } back_state_t;

endpackage

// ----- design/rfc_front.sv -----
// Rail fence front end: accepts input requests and marks each as kept or
// dropped by counting the bytes of the current message.
// Depends on rfc_pkg.
module rfc_front #(
    parameter int MAX_LEN = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rfc_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic                      s_tlast,
    input  logic                      q_full,
    output logic                      q_push,
    output rfc_pkg::item_t            q_item
);
    import rfc_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          keep;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign keep     = (cnt_reg < CW'(MAX_LEN));

    assign q_item.data = s_tdata;
    assign q_item.last = s_tlast;
    assign q_item.keep = keep;

    // message byte count, restarts after the last mark
    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (s_tlast) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/rfc_fifo.sv -----
// Two-entry request queue between the front end and the back end.
// Depends on rfc_pkg.
module rfc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rfc_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output rfc_pkg::item_t rd_item
);
    import rfc_pkg::*;

    item_t       ent_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_item = ent_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and occupancy update
    always_comb begin
        wp_next  = do_push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wp_reg] <= wr_item;
        end
    end

endmodule

// ----- design/rfc_back.sv -----
// Rail fence back end: message buffer, zigzag position walker, scatter
// memory for deciphering and a two-entry output queue.
// Depends on rfc_pkg.
module rfc_back #(
    parameter int MAX_LEN = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  rfc_pkg::item_t             q_item,
    output logic                       q_pop,
    input  logic [rfc_pkg::RAIL_W-1:0] rail_count,
    input  logic                       decrypt_mode,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output rfc_pkg::out_t              m_item
);
    import rfc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(3 * MAX_LEN);
    localparam int XW = (CW > RAIL_W) ? CW : RAIL_W;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] n_reg, n_next;
    logic          trunc_reg, trunc_next;
    logic          dec_reg, dec_next;
    logic          pass_reg, pass_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;

    // zigzag walker
    logic [CW-1:0] r_reg, r_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          ph_reg, ph_next;
    logic [CW-1:0] k_reg, k_next;

    // memories and read pipeline
    logic [BYTE_W-1:0] buf_mem [MAX_LEN];
    logic [BYTE_W-1:0] res_mem [MAX_LEN];
    logic [BYTE_W-1:0] buf_q, res_q;
    logic [AW-1:0]     buf_raddr, res_raddr;
    logic              wr_pend_reg;
    logic [AW-1:0]     wpos_reg;
    logic              rd_vld_reg, rd_last_reg, rd_trunc_reg, rd_dec_reg;

    // output queue
    out_t       oq_reg [2];
    logic       oq_wp_reg, oq_rp_reg;
    logic [1:0] oq_cnt_reg, oq_cnt_next;
    logic       oq_pop;
    logic [1:0] occ;
    out_t       oq_in;

    // control strobes
    logic          start, gen_step, k_clr, scat_issue, issue, issue_ok, k_last;
    logic [CW-1:0] n_cur;
    logic [PW-1:0] per, two_r, d_down, stp, pos_sum;

    assign n_cur  = fill_reg + CW'(q_item.keep);
    assign k_last = (k_reg == n_reg - CW'(1));

    // output queue occupancy counting the read still in flight
    assign oq_pop   = m_tvalid && m_tready;
    assign occ      = oq_cnt_reg + 2'(rd_vld_reg) - 2'(oq_pop);
    assign issue_ok = (occ < 2'd2);

    // zigzag step: alternate the down and up gaps of this rail
    always_comb begin
        per    = PW'((PW'(rcnt_reg) - PW'(1)) << 1);
        two_r  = PW'(PW'(r_reg) << 1);
        d_down = per - two_r;
        stp    = ph_reg ? two_r : d_down;
        if (stp == '0) begin
            stp = per;
        end
        pos_sum = pos_reg + stp;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        gen_step   = 1'b0;
        k_clr      = 1'b0;
        scat_issue = 1'b0;
        issue      = 1'b0;
        buf_raddr  = pos_reg[AW-1:0];
        res_raddr  = k_reg[AW-1:0];
        case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.last) begin
                        start      = 1'b1;
                        state_next = decrypt_mode ? ST_SCATTER : ST_EMIT;
                    end
                end
            end
            ST_SCATTER: begin
                buf_raddr  = k_reg[AW-1:0];
                scat_issue = 1'b1;
                gen_step   = 1'b1;
                if (k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                k_clr      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (issue_ok) begin
                    issue    = 1'b1;
                    gen_step = 1'b1;
                    if (k_last) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // run setup, fill tracking and walker update
    always_comb begin
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        trunc_next = trunc_reg;
        dec_next   = dec_reg;
        pass_next  = pass_reg;
        rcnt_next  = rcnt_reg;
        r_next     = r_reg;
        pos_next   = pos_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        if (start) begin
            n_next     = n_cur;
            trunc_next = ovf_reg || !q_item.keep;
            dec_next   = decrypt_mode;
            pass_next  = (rail_count <= RAIL_W'(1)) || (XW'(rail_count) >= XW'(n_cur));
            rcnt_next  = CW'(rail_count);
            fill_next  = '0;
            ovf_next   = 1'b0;
            r_next     = '0;
            pos_next   = '0;
            ph_next    = 1'b0;
            k_next     = '0;
        end else if (q_pop) begin
            fill_next = fill_reg + CW'(q_item.keep);
            ovf_next  = ovf_reg || !q_item.keep;
        end else if (k_clr) begin
            k_next = '0;
        end else if (gen_step) begin
            k_next = k_reg + CW'(1);
            if (pass_reg) begin
                pos_next = pos_reg + PW'(1);
            end else if (pos_sum >= PW'(n_reg)) begin
                r_next   = r_reg + CW'(1);
                pos_next = PW'(r_reg + CW'(1));
                ph_next  = 1'b0;
            end else begin
                pos_next = pos_sum;
                ph_next  = !ph_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            wr_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            oq_wp_reg    <= 1'b0;
            oq_rp_reg    <= 1'b0;
            oq_cnt_reg   <= 2'd0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            wr_pend_reg  <= scat_issue;
            rd_vld_reg   <= issue;
            oq_wp_reg    <= rd_vld_reg ? !oq_wp_reg : oq_wp_reg;
            oq_rp_reg    <= oq_pop ? !oq_rp_reg : oq_rp_reg;
            oq_cnt_reg   <= oq_cnt_next;
        end
    end

    assign oq_cnt_next = oq_cnt_reg + 2'(rd_vld_reg) - 2'(oq_pop);

    // run and walker registers, valid only while a run is active
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        trunc_reg    <= trunc_next;
        dec_reg      <= dec_next;
        pass_reg     <= pass_next;
        rcnt_reg     <= rcnt_next;
        r_reg        <= r_next;
        pos_reg      <= pos_next;
        ph_reg       <= ph_next;
        k_reg        <= k_next;
        wpos_reg     <= pos_reg[AW-1:0];
        rd_last_reg  <= k_last;
        rd_trunc_reg <= trunc_reg;
        rd_dec_reg   <= dec_reg;
    end

    // message buffer
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.keep) begin
            buf_mem[fill_reg[AW-1:0]] <= q_item.data;
        end
        buf_q <= buf_mem[buf_raddr];
    end

    // deciphered text, placed back along the zigzag
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            res_mem[wpos_reg] <= buf_q;
        end
        res_q <= res_mem[res_raddr];
    end

    // output queue
    always_comb begin
        oq_in.data  = rd_dec_reg ? res_q : buf_q;
        oq_in.last  = rd_last_reg;
        oq_in.trunc = rd_trunc_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            oq_reg[oq_wp_reg] <= oq_in;
        end
    end

    assign m_tvalid = (oq_cnt_reg != 2'd0);
    assign m_item   = oq_reg[oq_rp_reg];

endmodule

// ----- design/rail_fence_cipher.sv -----
// Rail fence cipher, top level. Load: one byte per cycle into the buffer while
// the back end is loading. Run of n bytes: enciphering emits one result per
// cycle while the output queue has room; deciphering first scatters the text
// into the result memory, then emits one per cycle. Rate is set by the single
// read port of the message buffer. Reset is synchronous, active low: control
// clears, rail_count = 3, decrypt_mode = 0; buffer contents are not cleared.
module rail_fence_cipher #(
    parameter int MAX_LEN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic                          m_tuser    // [0] truncated
);
    import rfc_pkg::*;

    logic [RAIL_W-1:0] rail_count_reg;
    logic              decrypt_mode_reg;
    logic              q_push, q_full, q_pop, q_valid;
    item_t             q_wr_item, q_rd_item;
    out_t              m_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_count_reg   <= RAIL_COUNT_RST;
            decrypt_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RAIL_COUNT:   rail_count_reg   <= cfg_wdata;
                CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    rfc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_wr_item)
    );

    rfc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_item (q_rd_item)
    );

    rfc_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_rd_item),
        .q_pop        (q_pop),
        .rail_count   (rail_count_reg),
        .decrypt_mode (decrypt_mode_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_item       (m_item)
    );

    assign m_tdata = m_item.data;
    assign m_tlast = m_item.last;
    assign m_tuser = m_item.trunc;

endmodule

// ----- tb/rail_fence_cipher_checker.sv -----
// Scoreboard for the rail fence cipher: tracks the key registers, rebuilds each
// message from the accepted input requests and checks every result request.
// Depends on rfc_pkg for register indexes and the result request type.
`timescale 1ns / 100ps

module rail_fence_cipher_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,   // [7:0] out_byte
    input  logic                          m_tlast,
    input  logic                          m_tuser,   // [0] truncated
    output int                            fail_count,
    output int                            pending
);
    import rfc_pkg::*;

    // cipher text still owed by the block, oldest first
    out_t cipher_q[$];

    // mirror of the block's message store and key
    logic [7:0]        msg_buf [MAX_LEN];
    int unsigned       msg_len;
    logic              dropped;
    logic [RAIL_W-1:0] rails_cfg;
    logic              decipher_cfg;

    // rail that message position pos lands on in the zigzag
    function automatic int unsigned rail_at(int unsigned pos, int unsigned rails);
        int unsigned period;
        int unsigned p;
        if (rails <= 1)
            return 0;
        period = 2 * (rails - 1);
        p = pos % period;
        return (p < rails) ? p : period - p;
    endfunction

    // reorder the held message and queue one result per byte
    task automatic encode_message();
        int unsigned order [MAX_LEN];
        logic [7:0]  text [MAX_LEN];
        int unsigned rails;
        int unsigned k;
        out_t        res;
        rails = (rails_cfg == 0) ? 1 : rails_cfg;
        // order[k]: message position taken k-th when reading rail by rail
        k = 0;
        for (int unsigned rr = 0; rr < rails && k < msg_len; rr++)
            for (int unsigned i = 0; i < msg_len; i++)
                if (rail_at(i, rails) == rr) begin
                    order[k] = i;
                    k++;
                end
        for (int unsigned j = 0; j < msg_len; j++) begin
            if (decipher_cfg)
                text[order[j]] = msg_buf[j];
            else
                text[j] = msg_buf[order[j]];
        end
        for (int unsigned j = 0; j < msg_len; j++) begin
            res.data  = text[j];
            res.last  = (j + 1 == msg_len);
            res.trunc = dropped;
            cipher_q.push_back(res);
        end
        msg_len = 0;
        dropped = 1'b0;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            msg_len      = 0;
            dropped      = 1'b0;
            rails_cfg    = RAIL_COUNT_RST;
            decipher_cfg = 1'b0;
            cipher_q.delete();
        end else begin
            // key updates
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RAIL_COUNT:   rails_cfg = cfg_wdata[RAIL_W-1:0];
                    CFG_DECRYPT_MODE: decipher_cfg = cfg_wdata[0];
                    default: ;
                endcase
            end
            // input request: store or drop, close the message on last
            if (s_tvalid && s_tready) begin
                if (msg_len < MAX_LEN) begin
                    msg_buf[msg_len] = s_tdata;
                    msg_len++;
                end else begin
                    dropped = 1'b1;
                end
                if (s_tlast)
                    encode_message();
            end
            // result request against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    $error("result request with none expected: out_byte=%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== want.trunc) begin
                        $error("truncated: expected %0b, got %0b", want.trunc, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        pending = cipher_q.size();
    end

endmodule

// ----- tb/rail_fence_cipher_tb.sv -----
// Top of the rail fence cipher testbench: clock, reset, message and key
// stimulus, receiver back-pressure, watchdog and verdict.
// Depends on rfc_pkg, rail_fence_cipher and rail_fence_cipher_checker.
`timescale 1ns / 100ps

module rail_fence_cipher_tb;
    import rfc_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int ITEM_TARGET    = 410;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 2 * MAX_LEN + 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] in_byte
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [7:0] out_byte
    logic                 m_tlast;
    logic                 m_tuser;   // [0] truncated

    int fail_count;
    int pending;
    int items_sent    = 0;
    int results_taken = 0;
    int idle_cycles   = 0;
    bit quiet_phase   = 1'b0;
    bit hold_done     = 1'b0;

    rail_fence_cipher #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rail_fence_cipher_checker #(
        .MAX_LEN(MAX_LEN)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // progress watchdog and result counter
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready)
            results_taken <= results_taken + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in a quiet phase
    function automatic int pick_gap();
        if (quiet_phase)
            return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 0;
            6, 7, 8:          return $urandom_range(1, 3);
            default:          return $urandom_range(5, 30);
        endcase
    endfunction

    // key choice leans on the extremes and on small rail counts
    function automatic int unsigned pick_rails();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 63;
            4:       return 64;
            5:       return 127;
            6, 7:    return $urandom_range(2, 9);
            default: return $urandom_range(3, 64);
        endcase
    endfunction

    // mostly short messages, some at the buffer size and some past it
    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(1, 12);
            6, 7:             return $urandom_range(13, 40);
            8:                return $urandom_range(60, 64);
            default:          return $urandom_range(65, 72);
        endcase
    endfunction

    // offer one input request and hold it until taken
    task automatic put_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = l;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // one message; with extremes set it opens with 00 and FF
    task automatic send_message(input int len, input bit extremes);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            b = $urandom_range(0, 255);
            if (extremes && k == 0)
                b = 8'h00;
            else if (extremes && k == 1)
                b = 8'hFF;
            put_byte(b, k == len - 1);
        end
    endtask

    // key write once the block has drained and settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // receiver: random stalls plus one long hold while input is offered
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_taken >= HOLD_AFTER && s_tvalid) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // stimulus and verdict
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_RAIL_COUNT;
        cfg_wdata = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset key (3 rails, encipher), single byte, decipher,
        // one rail, zero rails, rails beyond the length
        send_message(7, 1'b1);
        send_message(1, 1'b0);
        write_reg(CFG_DECRYPT_MODE, 1);
        send_message(7, 1'b1);
        write_reg(CFG_RAIL_COUNT, 1);
        write_reg(CFG_DECRYPT_MODE, 0);
        send_message(3, 1'b0);
        write_reg(CFG_RAIL_COUNT, 0);
        send_message(3, 1'b0);
        write_reg(CFG_RAIL_COUNT, 127);
        write_reg(CFG_DECRYPT_MODE, 1);
        send_message(4, 1'b0);

        // random phases: new key, then a few messages
        while (items_sent < ITEM_TARGET) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            write_reg(CFG_RAIL_COUNT, pick_rails());
            // upper data bits are don't-care for the mode register
            write_reg(CFG_DECRYPT_MODE,
                      ($urandom_range(0, 63) << 1) | $urandom_range(0, 1));
            repeat ($urandom_range(1, 4))
                if (items_sent < ITEM_TARGET)
                    send_message(pick_length(), 1'b0);
        end
        s_tvalid    = 1'b0;
        quiet_phase = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
